// ===== src/hcbd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcbd_pkg
// Shared types, codes and constants of the chunked body decoder.
// ----------------------------------------------------------------------------
package hcbd_pkg;

  localparam int unsigned SIZE_WIDTH_DEF = 32;
  localparam int unsigned LINE_LIM_W     = 16;
  localparam int unsigned BODY_LIM_W     = 32;
  localparam int unsigned CFG_DATA_W     = 32;
  localparam int unsigned CFG_IDX_W      = 1;

  localparam logic [LINE_LIM_W-1:0] LINE_LIM_RST = 16'd1024;
  localparam logic [BODY_LIM_W-1:0] BODY_LIM_RST = 32'd33554432;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_LINE_LIMIT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BODY_LIMIT      = 1'b1;

  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_SP   = 8'h20;
  localparam logic [7:0] CH_TAB  = 8'h09;
  localparam logic [7:0] CH_SEMI = 8'h3B;

  typedef enum logic [1:0] {
    EV_BYTE = 2'd0,
    EV_DONE = 2'd1,
    EV_ERR  = 2'd2
  } event_kind_t;

  typedef enum logic [2:0] {
    ERR_LINE_LONG = 3'd0,
    ERR_BAD_CHAR  = 3'd1,
    ERR_SIZE_OVF  = 3'd2,
    ERR_NO_CRLF   = 3'd3,
    ERR_BODY_BIG  = 3'd4,
    ERR_EARLY_END = 3'd5
  } error_code_t;

  typedef struct packed {
    event_kind_t kind;
    logic [7:0]  data;
    error_code_t code;
  } out_item_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  function automatic hex_t hex_digit(input logic [7:0] b);
    hex_t h;
    logic [7:0] t;
    h = '{ok: 1'b0, val: 4'd0};
    t = 8'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      t = b - 8'h30;
      h = '{ok: 1'b1, val: t[3:0]};
    end else if (b >= 8'h61 && b <= 8'h66) begin
      t = b - 8'h57;
      h = '{ok: 1'b1, val: t[3:0]};
    end else if (b >= 8'h41 && b <= 8'h46) begin
      t = b - 8'h37;
      h = '{ok: 1'b1, val: t[3:0]};
    end
    return h;
  endfunction

endpackage

// ===== src/hcbd_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcbd_in_if
// Raw stream channel: one body byte or a peer close per transfer.
// ----------------------------------------------------------------------------
interface hcbd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       stream_closed;

  modport source (output valid, output data_byte, output stream_closed, input ready);
  modport sink   (input valid, input data_byte, input stream_closed, output ready);
endinterface

// ===== src/hcbd_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcbd_out_if
// Event channel: payload byte, body complete or error per transfer.
// ----------------------------------------------------------------------------
interface hcbd_out_if;
  logic                     valid;
  logic                     ready;
  hcbd_pkg::event_kind_t    event_kind;
  logic [7:0]               payload_byte;
  hcbd_pkg::error_code_t    error_code;

  modport source (output valid, output event_kind, output payload_byte, output error_code,
                  input ready);
  modport sink   (input valid, input event_kind, input payload_byte, input error_code,
                  output ready);
endinterface

// ===== src/http_chunked_body_decoder_core.sv =====
`timescale 1ns / 1ps
// HTTP/1.1 chunked body decoder. Takes one byte per transfer and gives at most
// one event per byte: a payload byte, body complete, or an error (after which
// the decoder restarts; limits are kept). Every byte is resolved in the cycle
// it is taken, directly from the parser registers, and its event lands in an
// output register backed by a one-entry skid stage, so the decoder sustains
// one byte per clock; in_ch.ready drops only while the skid stage is full,
// i.e. after the event sink has stalled on a held event as a new result came
// in. There is no memory and no clearing pass after reset. Write the limits
// only while the decoder is idle.
// ----------------------------------------------------------------------------
// http_chunked_body_decoder_core
// Size line parser, chunk payload pass-through, trailer skip and error report.
// ----------------------------------------------------------------------------
module http_chunked_body_decoder_core #(
  parameter int unsigned SIZE_WIDTH = hcbd_pkg::SIZE_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  hcbd_in_if.sink                          in_ch,
  hcbd_out_if.source                       out_ch,
  input  logic                             cfg_wr_en,
  input  logic [hcbd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [hcbd_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  typedef enum logic [2:0] {
    PH_SIZE    = 3'd0,
    PH_DATA    = 3'd1,
    PH_CRLF    = 3'd2,
    PH_CRLF_CR = 3'd3,
    PH_TRL     = 3'd4,
    PH_TRL_CR  = 3'd5
  } phase_t;

  phase_t                              phase_r, phase_nxt;
  logic [SIZE_WIDTH-1:0]               size_accum_r, size_accum_nxt;
  logic [SIZE_WIDTH-1:0]               chunk_left_r, chunk_left_nxt;
  logic [hcbd_pkg::LINE_LIM_W-1:0]     line_len_r, line_len_nxt;
  logic [hcbd_pkg::BODY_LIM_W-1:0]     body_total_r, body_total_nxt;
  logic                                digit_r, digit_nxt;
  logic                                blank_r, blank_nxt;
  logic                                ext_r, ext_nxt;
  logic                                line_nonempty_r, line_nonempty_nxt;

  logic [hcbd_pkg::LINE_LIM_W-1:0]     line_lim_r;
  logic [hcbd_pkg::BODY_LIM_W-1:0]     body_lim_r;

  logic                                out_v_r, skid_v_r;
  hcbd_pkg::out_item_t                 out_item_r, skid_item_r;

  logic                                accept, take;
  logic                                res_v, clear;
  hcbd_pkg::out_item_t                 res;
  hcbd_pkg::hex_t                      hx;
  logic [7:0]                          b;

  assign in_ch.ready = !skid_v_r;
  assign accept      = in_ch.valid && in_ch.ready;
  assign take        = out_v_r && out_ch.ready;
  assign b           = in_ch.data_byte;
  assign hx          = hcbd_pkg::hex_digit(b);

  assign out_ch.valid        = out_v_r;
  assign out_ch.event_kind   = out_item_r.kind;
  assign out_ch.payload_byte = out_item_r.data;
  assign out_ch.error_code   = out_item_r.code;

  always_comb begin
    phase_nxt         = phase_r;
    size_accum_nxt    = size_accum_r;
    chunk_left_nxt    = chunk_left_r;
    line_len_nxt      = line_len_r;
    body_total_nxt    = body_total_r;
    digit_nxt         = digit_r;
    blank_nxt         = blank_r;
    ext_nxt           = ext_r;
    line_nonempty_nxt = line_nonempty_r;
    res_v             = 1'b0;
    clear             = 1'b0;
    res               = '{kind: hcbd_pkg::EV_BYTE, data: 8'd0, code: hcbd_pkg::ERR_LINE_LONG};

    if (in_ch.stream_closed) begin
      // close at idle is silent; anywhere else the body is cut short
      if (!(phase_r == PH_SIZE && line_len_r == '0 && body_total_r == '0)) begin
        res_v    = 1'b1;
        clear    = 1'b1;
        res.kind = hcbd_pkg::EV_ERR;
        res.code = hcbd_pkg::ERR_EARLY_END;
      end
    end else begin
      case (phase_r)
        PH_SIZE: begin
          if (b == hcbd_pkg::CH_LF) begin
            size_accum_nxt = '0;
            line_len_nxt   = '0;
            digit_nxt      = 1'b0;
            blank_nxt      = 1'b0;
            ext_nxt        = 1'b0;
            if (size_accum_r == '0) begin
              phase_nxt         = PH_TRL;
              line_nonempty_nxt = 1'b0;
            end else begin
              chunk_left_nxt = size_accum_r;
              phase_nxt      = PH_DATA;
            end
          end else if (line_len_r >= line_lim_r) begin
            res_v    = 1'b1;
            clear    = 1'b1;
            res.kind = hcbd_pkg::EV_ERR;
            res.code = hcbd_pkg::ERR_LINE_LONG;
          end else begin
            line_len_nxt = line_len_r + 1'b1;
            if (ext_r) begin
              // skip extension text
            end else if (b == hcbd_pkg::CH_SEMI) begin
              ext_nxt = 1'b1;
            end else if (b inside {hcbd_pkg::CH_SP, hcbd_pkg::CH_TAB, hcbd_pkg::CH_CR}) begin
              if (digit_r) blank_nxt = 1'b1;
            end else if (!hx.ok || blank_r) begin
              res_v    = 1'b1;
              clear    = 1'b1;
              res.kind = hcbd_pkg::EV_ERR;
              res.code = hcbd_pkg::ERR_BAD_CHAR;
            end else if (size_accum_r[SIZE_WIDTH-1 -: 4] != 4'd0) begin
              res_v    = 1'b1;
              clear    = 1'b1;
              res.kind = hcbd_pkg::EV_ERR;
              res.code = hcbd_pkg::ERR_SIZE_OVF;
            end else begin
              size_accum_nxt = {size_accum_r[SIZE_WIDTH-5:0], hx.val};
              digit_nxt      = 1'b1;
            end
          end
        end
        PH_DATA: begin
          if (body_total_r >= body_lim_r) begin
            res_v    = 1'b1;
            clear    = 1'b1;
            res.kind = hcbd_pkg::EV_ERR;
            res.code = hcbd_pkg::ERR_BODY_BIG;
          end else begin
            body_total_nxt = body_total_r + 1'b1;
            chunk_left_nxt = chunk_left_r - 1'b1;
            if (chunk_left_r == SIZE_WIDTH'(1)) phase_nxt = PH_CRLF;
            res_v    = 1'b1;
            res.kind = hcbd_pkg::EV_BYTE;
            res.data = b;
          end
        end
        PH_CRLF: begin
          if (b == hcbd_pkg::CH_LF) begin
            phase_nxt = PH_SIZE;
          end else if (b == hcbd_pkg::CH_CR) begin
            phase_nxt = PH_CRLF_CR;
          end else begin
            res_v    = 1'b1;
            clear    = 1'b1;
            res.kind = hcbd_pkg::EV_ERR;
            res.code = hcbd_pkg::ERR_NO_CRLF;
          end
        end
        PH_CRLF_CR: begin
          if (b == hcbd_pkg::CH_LF) begin
            phase_nxt = PH_SIZE;
          end else begin
            res_v    = 1'b1;
            clear    = 1'b1;
            res.kind = hcbd_pkg::EV_ERR;
            res.code = hcbd_pkg::ERR_NO_CRLF;
          end
        end
        PH_TRL: begin
          if (b == hcbd_pkg::CH_LF) begin
            if (!line_nonempty_r) begin
              res_v    = 1'b1;
              clear    = 1'b1;
              res.kind = hcbd_pkg::EV_DONE;
            end else begin
              line_nonempty_nxt = 1'b0;
            end
          end else if (b == hcbd_pkg::CH_CR && !line_nonempty_r) begin
            phase_nxt = PH_TRL_CR;
          end else begin
            line_nonempty_nxt = 1'b1;
          end
        end
        PH_TRL_CR: begin
          if (b == hcbd_pkg::CH_LF) begin
            res_v    = 1'b1;
            clear    = 1'b1;
            res.kind = hcbd_pkg::EV_DONE;
          end else begin
            line_nonempty_nxt = 1'b1;
            phase_nxt         = PH_TRL;
          end
        end
        default: begin
          clear = 1'b1;
        end
      endcase
    end

    // drop back to the restart state after completion or error
    if (clear) begin
      phase_nxt         = PH_SIZE;
      size_accum_nxt    = '0;
      chunk_left_nxt    = '0;
      line_len_nxt      = '0;
      body_total_nxt    = '0;
      digit_nxt         = 1'b0;
      blank_nxt         = 1'b0;
      ext_nxt           = 1'b0;
      line_nonempty_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= PH_SIZE;
      size_accum_r    <= '0;
      chunk_left_r    <= '0;
      line_len_r      <= '0;
      body_total_r    <= '0;
      digit_r         <= 1'b0;
      blank_r         <= 1'b0;
      ext_r           <= 1'b0;
      line_nonempty_r <= 1'b0;
      line_lim_r      <= hcbd_pkg::LINE_LIM_RST;
      body_lim_r      <= hcbd_pkg::BODY_LIM_RST;
      out_v_r         <= 1'b0;
      skid_v_r        <= 1'b0;
    end else begin
      if (accept) begin
        phase_r         <= phase_nxt;
        size_accum_r    <= size_accum_nxt;
        chunk_left_r    <= chunk_left_nxt;
        line_len_r      <= line_len_nxt;
        body_total_r    <= body_total_nxt;
        digit_r         <= digit_nxt;
        blank_r         <= blank_nxt;
        ext_r           <= ext_nxt;
        line_nonempty_r <= line_nonempty_nxt;
      end
      if (cfg_wr_en) begin
        case (cfg_index)
          hcbd_pkg::CFG_SIZE_LINE_LIMIT: line_lim_r <= cfg_wdata[hcbd_pkg::LINE_LIM_W-1:0];
          hcbd_pkg::CFG_BODY_LIMIT:      body_lim_r <= cfg_wdata[hcbd_pkg::BODY_LIM_W-1:0];
          default: ;
        endcase
      end
      if (take || !out_v_r) begin
        if (skid_v_r) begin
          out_v_r  <= 1'b1;
          skid_v_r <= 1'b0;
        end else begin
          out_v_r <= accept && res_v;
        end
      end else if (accept && res_v) begin
        skid_v_r <= 1'b1;
      end
    end

    // payload side: advance from skid, else take the fresh result
    if (take || !out_v_r) begin
      out_item_r <= skid_v_r ? skid_item_r : res;
    end else if (accept && res_v) begin
      skid_item_r <= res;
    end
  end

endmodule

// ===== src/hcbd_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcbd_checker
// Port-level checks of the chunked body decoder, bound to the top level.
// ----------------------------------------------------------------------------
module hcbd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_event_kind,
  input logic [7:0] out_payload_byte,
  input logic [2:0] out_error_code
);

  // a stall on the input side only happens with an event pending
  a_ready_needs_pending: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with no pending event");

  // no event appears without a byte transfer or a waiting event
  a_no_invented_event: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid && !(in_valid && in_ready)) |=> !out_valid)
    else $error("event appeared without an input transfer");

  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("event valid right after reset");

  // unused fields are zero for the event kind shown
  a_field_encoding: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_event_kind == hcbd_pkg::EV_BYTE && out_error_code == 3'd0) ||
                   (out_event_kind == hcbd_pkg::EV_DONE && out_error_code == 3'd0 &&
                    out_payload_byte == 8'd0) ||
                   (out_event_kind == hcbd_pkg::EV_ERR && out_payload_byte == 8'd0 &&
                    out_error_code <= 3'd5)))
    else $error("event fields inconsistent with event kind");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_event_kind) &&
                                   $stable(out_payload_byte) && $stable(out_error_code)))
    else $error("stalled event changed");

endmodule

bind http_chunked_body_decoder_core hcbd_checker u_hcbd_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_event_kind   (out_ch.event_kind),
  .out_payload_byte (out_ch.payload_byte),
  .out_error_code   (out_ch.error_code)
);
